// File: design/rational_approx_continued_fraction_macros.svh
// ----------------------------------------------------------------------------
// rational approximation assertion macros
// shared property templates for the checker, clocked on i_clk with reset
// ----------------------------------------------------------------------------
`ifndef RATIONAL_APPROX_CONTINUED_FRACTION_MACROS_SVH
`define RATIONAL_APPROX_CONTINUED_FRACTION_MACROS_SVH

// same-cycle implication
`define RAC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rac assertion failed");

// next-cycle implication
`define RAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rac assertion failed");

`endif

// File: design/rac_pkg.sv
// ----------------------------------------------------------------------------
// rac_pkg
// widths, reset values and register codes of the rational approximator
// ----------------------------------------------------------------------------
package rac_pkg;

    localparam int VALUE_W   = 64;
    localparam int NUM_W     = 64;
    localparam int DEN_W     = 33;
    localparam int TERMS_W   = 7;
    localparam int MAXT_W    = 7;
    localparam int PREC_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam int FRAC_BITS_DEFAULT = 32;

    // hard cap on the number of terms
    localparam logic [MAXT_W-1:0] TERM_LIMIT = 7'd64;

    localparam logic [MAXT_W-1:0] MAXT_RESET = 7'd32;
    localparam logic [PREC_W-1:0] PREC_RESET = 32'd4295;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_TERMS = 1'b0,
        CFG_PRECISION = 1'b1
    } t_cfg_index;

endpackage

// File: design/rac_if.sv
// ----------------------------------------------------------------------------
// rac channel interfaces
// valid/ready channels for the input value and the resulting fraction
// ----------------------------------------------------------------------------
interface rac_in_if
    import rac_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rac_out_if
    import rac_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [NUM_W-1:0] numerator;
    logic [DEN_W-1:0]        denominator;
    logic [TERMS_W-1:0]      terms_used;

    modport source (output valid, output numerator, output denominator,
                    output terms_used, input ready);
    modport sink   (input valid, input numerator, input denominator,
                    input terms_used, output ready);
endinterface

// File: design/rational_approx_continued_fraction.sv
// ----------------------------------------------------------------------------
// rational_approx_continued_fraction
// best rational approximation of a signed fixed-point value by convergents
// ----------------------------------------------------------------------------
// A signed fixed-point value (FRAC_BITS fraction bits, Q31.32 by default) is
// turned into numerator/denominator by continued-fraction convergents. The
// work is exact integer arithmetic on the remainder ratio rem/div, so no
// rounding builds up. One value is in flight at a time: i_in.ready is high
// only while the sequencer is idle. Each term is one pass of the radix-2
// restoring divider that produces one quotient bit per cycle while the same
// pass shift-adds the quotient into both convergents (Horner form).
// The result sits in an output register, so a new value is taken while the
// previous result still waits. max_terms and precision must be written only
// while the block is idle; max_terms above 64 is clamped to 64.
// ----------------------------------------------------------------------------
module rational_approx_continued_fraction
    import rac_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    rac_in_if.sink               i_in,
    rac_out_if.source            o_out
);

    // divisor width: div runs up to 2^FRAC_BITS
    localparam int D_W    = FRAC_BITS + 1;
    localparam int BIT_W  = $clog2(D_W);
    localparam int PROD_W = PREC_W + D_W;

    typedef enum logic [2:0] {
        IDLE,
        CHECK,
        TEST,
        DIVIDE,
        UPDATE,
        FINISH
    } t_state;

    t_state              r_state;

    // configuration
    logic [MAXT_W-1:0]   r_max_terms;
    logic [PREC_W-1:0]   r_precision;

    // convergent pairs and remainder ratio
    logic                r_pos;
    logic [NUM_W-1:0]    r_p;
    logic [NUM_W-1:0]    r_pp;
    logic [D_W-1:0]      r_q;
    logic [D_W-1:0]      r_qp;
    logic [D_W-1:0]      r_div;
    logic [FRAC_BITS-1:0] r_rem;

    // divider and horner accumulators
    logic [D_W-1:0]      r_part;
    logic [NUM_W-1:0]    r_accp;
    logic [D_W-1:0]      r_accq;
    logic [BIT_W-1:0]    r_bit;

    logic [TERMS_W-1:0]  r_count;
    logic [TERMS_W-1:0]  r_limit;
    logic [PROD_W-1:0]   r_prod;

    // output register
    logic                r_out_valid;
    logic [NUM_W-1:0]    r_numerator;
    logic [DEN_W-1:0]    r_denominator;
    logic [TERMS_W-1:0]  r_terms;

    // input decode: magnitude and sign, zero counts as negative
    logic [VALUE_W-1:0]  w_raw;
    logic                w_pos;
    logic [VALUE_W-1:0]  w_mag;

    // one divider step
    logic [D_W-1:0]      w_shift;
    logic [D_W-1:0]      w_rem_ext;
    logic                w_ge;
    logic [D_W-1:0]      w_part_nxt;
    logic [NUM_W-1:0]    w_accp_nxt;
    logic [D_W-1:0]      w_accq_nxt;

    // stop test
    logic [PROD_W-1:0]   w_lhs;
    logic                w_go;

    assign w_raw = i_in.value;
    assign w_pos = !w_raw[VALUE_W-1] && (w_raw != '0);
    assign w_mag = w_pos ? w_raw : (VALUE_W'(0) - w_raw);

    // partial remainder stays below rem < 2^FRAC_BITS, so its top bit is zero
    assign w_shift    = {r_part[D_W-2:0], r_div[r_bit]};
    assign w_rem_ext  = {1'b0, r_rem};
    assign w_ge       = (w_shift >= w_rem_ext);
    assign w_part_nxt = w_ge ? (w_shift - w_rem_ext) : w_shift;
    assign w_accp_nxt = {r_accp[NUM_W-2:0], 1'b0} + (w_ge ? r_p : NUM_W'(0));
    assign w_accq_nxt = {r_accq[D_W-2:0], 1'b0} + (w_ge ? r_q : D_W'(0));

    // rem/div > precision/2^32 as rem*2^32 > precision*div
    assign w_lhs = PROD_W'({r_rem, {PREC_W{1'b0}}});
    assign w_go  = (w_lhs > r_prod) && (r_count < r_limit);

    assign i_in.ready        = (r_state == IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.numerator   = r_numerator;
    assign o_out.denominator = r_denominator;
    assign o_out.terms_used  = r_terms;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_terms <= MAXT_RESET;
            r_precision <= PREC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_TERMS: r_max_terms <= i_cfg_data[MAXT_W-1:0];
                CFG_PRECISION: r_precision <= i_cfg_data[PREC_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a taken result clears, FINISH handles its own cycle
            if (r_out_valid && o_out.ready && (r_state != FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                IDLE: begin
                    if (i_in.valid) begin
                        r_pos   <= w_pos;
                        r_p     <= NUM_W'(w_mag >> FRAC_BITS);
                        r_rem   <= w_mag[FRAC_BITS-1:0];
                        r_div   <= {1'b1, {FRAC_BITS{1'b0}}};
                        r_q     <= D_W'(1);
                        r_pp    <= NUM_W'(1);
                        r_qp    <= '0;
                        r_count <= '0;
                        r_limit <= (r_max_terms > TERM_LIMIT) ? TERM_LIMIT : r_max_terms;
                        r_state <= CHECK;
                    end
                end
                CHECK: begin
                    r_prod  <= PROD_W'(r_precision) * PROD_W'(r_div);
                    r_state <= TEST;
                end
                TEST: begin
                    if (w_go) begin
                        r_part  <= '0;
                        r_accp  <= '0;
                        r_accq  <= '0;
                        r_bit   <= BIT_W'(D_W - 1);
                        r_state <= DIVIDE;
                    end else begin
                        r_state <= FINISH;
                    end
                end
                DIVIDE: begin
                    r_part <= w_part_nxt;
                    r_accp <= w_accp_nxt;
                    r_accq <= w_accq_nxt;
                    if (r_bit == '0) begin
                        r_state <= UPDATE;
                    end else begin
                        r_bit <= r_bit - BIT_W'(1);
                    end
                end
                UPDATE: begin
                    // p' = a*p + p_prev, q' = a*q + q_prev, ratio becomes (div mod rem)/rem
                    r_pp    <= r_p;
                    r_qp    <= r_q;
                    r_p     <= r_accp + r_pp;
                    r_q     <= r_accq + r_qp;
                    r_div   <= w_rem_ext;
                    r_rem   <= r_part[FRAC_BITS-1:0];
                    r_count <= r_count + TERMS_W'(1);
                    r_state <= CHECK;
                end
                FINISH: begin
                    // wait here only while an earlier result is still untaken
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid   <= 1'b1;
                        r_numerator   <= r_pos ? r_p : (NUM_W'(0) - r_p);
                        r_denominator <= DEN_W'(r_q);
                        r_terms       <= r_count;
                        r_state       <= IDLE;
                    end
                end
                default: r_state <= IDLE;
            endcase
        end
    end

endmodule

// File: design/rac_checker.sv
// ----------------------------------------------------------------------------
// rac_checker
// port-level checks of the rational approximator, bound to the top level
// ----------------------------------------------------------------------------
`include "rational_approx_continued_fraction_macros.svh"

module rac_checker
    import rac_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [NUM_W-1:0]   i_numerator,
    input logic [DEN_W-1:0]   i_denominator,
    input logic [TERMS_W-1:0] i_terms_used
);

    // a transaction on the input starts the sequencer, which drops ready
    `RAC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // convergent denominators never vanish
    `RAC_ASSERT_SAME(a_den_nonzero, i_out_valid, i_denominator != '0)

    // term count never exceeds the hard cap
    `RAC_ASSERT_SAME(a_terms_capped, i_out_valid, i_terms_used <= TERM_LIMIT)

    // a stalled result holds
    `RAC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
                     i_out_valid && $stable(i_numerator) && $stable(i_denominator))

endmodule

bind rational_approx_continued_fraction rac_checker u_rac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_numerator   (o_out.numerator),
    .i_denominator (o_out.denominator),
    .i_terms_used  (o_out.terms_used)
);

// File: tb/rational_approx_continued_fraction_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_approx_continued_fraction_tb
// self-checking bench for the continued-fraction rational approximator
// ----------------------------------------------------------------------------
// Values go in through a queue-fed driver. A monitor predicts each fraction at
// the input transaction and checks the output transactions in order. The run
// moves through several max_terms/precision settings, including both
// extremes, with random stalls on both channels but for a last stall-free part.
// ----------------------------------------------------------------------------
module rational_approx_continued_fraction_tb;
    import rac_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEFAULT;
    // end wait: long enough for three full-length values of 64 terms
    localparam int END_WAIT    = 3 * (3 + 64 * (FRAC + 4));
    localparam int CYCLE_LIMIT = 3_000_000;

    // one expected output transaction
    typedef struct packed {
        logic [NUM_W-1:0]   numerator;
        logic [DEN_W-1:0]   denominator;
        logic [TERMS_W-1:0] terms_used;
    } fraction_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    rac_in_if  in_ch ();
    rac_out_if out_ch ();

    rational_approx_continued_fraction #(
        .FRAC_BITS (FRAC)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // bench copy of the two registers
    logic [MAXT_W-1:0] term_budget;
    logic [PREC_W-1:0] stop_threshold;

    logic [VALUE_W-1:0] values_to_send[$];
    fraction_t          fractions_due[$];

    int unsigned issued;
    int unsigned received;
    int unsigned mismatches;
    int unsigned settings_run;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycle_count;
    logic        in_taken;

    // ------------------------------------------------------------------------
    // predictor: exact euclid on rem/div, convergents p/q with previous pair
    // ------------------------------------------------------------------------
    function automatic fraction_t approximate(input logic [VALUE_W-1:0] raw,
                                              input logic [MAXT_W-1:0] budget,
                                              input logic [PREC_W-1:0] threshold);
        logic        positive;
        logic [63:0] mag, div, rem, p, q, pp, qp, a, nrem, np, nq, limit, count;
        fraction_t   res;
        // zero counts as negative, which makes no difference to the result
        positive = !raw[63] && (raw != 0);
        mag      = positive ? raw : -raw;
        div      = 64'd1 << FRAC;
        rem      = mag & (div - 64'd1);
        p        = mag >> FRAC;
        q        = 64'd1;
        pp       = 64'd1;
        qp       = 64'd0;
        limit    = (budget > TERM_LIMIT) ? 64'(TERM_LIMIT) : 64'(budget);
        count    = 64'd0;
        // rem/div > threshold/2^32, exact; a zero remainder always stops here
        while (((rem << 32) > (64'(threshold) * div)) && (count < limit)) begin
            a     = div / rem;
            nrem  = div % rem;
            np    = a * p + pp;
            nq    = a * q + qp;
            pp    = p;
            qp    = q;
            p     = np;
            q     = nq;
            div   = rem;
            rem   = nrem;
            count = count + 64'd1;
        end
        res.numerator   = positive ? p : -p;
        res.denominator = q[DEN_W-1:0];
        res.terms_used  = count[TERMS_W-1:0];
        return res;
    endfunction

    // random value: raw patterns, small integer parts, near simple rationals
    // and short dyadic fractions, either sign
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned kind, d, n;
        logic [31:0] whole, frac;
        logic [63:0] v;
        kind = $urandom_range(3);
        case (kind)
            0: begin
                v = {$urandom, $urandom};
            end
            1: begin
                whole = $urandom_range(0, 15);
                frac  = $urandom;
                v     = {whole, frac};
            end
            2: begin
                d     = $urandom_range(1, 999);
                n     = $urandom_range(0, d - 1);
                frac  = 32'(((64'(n) << 32) + 64'(d / 2)) / 64'(d));
                frac  = frac + $urandom_range(0, 2);
                whole = $urandom_range(0, 255);
                v     = {whole, frac};
            end
            default: begin
                whole = $urandom_range(0, 3);
                frac  = $urandom & ~(32'hFFFF_FFFF >> $urandom_range(1, 12));
                v     = {whole, frac};
            end
        endcase
        if (kind != 0 && $urandom_range(1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v);
        values_to_send.push_back(v);
        issued++;
    endtask

    // block is idle once every issued value has come back
    task automatic wait_idle();
        while (issued != received) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_MAX_TERMS: term_budget    = data[MAXT_W-1:0];
            CFG_PRECISION: stop_threshold = data[PREC_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // new register setting, then a batch of random values under it
    task automatic run_setting(input logic [MAXT_W-1:0] budget,
                               input logic [PREC_W-1:0] threshold,
                               input int unsigned count);
        wait_idle();
        write_register(CFG_MAX_TERMS, CFG_W'(budget));
        write_register(CFG_PRECISION, CFG_W'(threshold));
        settings_run++;
        repeat (count) send_value(random_value());
    endtask

    // ------------------------------------------------------------------------
    // clock, everything known from time zero
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // driver: one transaction at a time off the queue, random sender gaps
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (values_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.value <= values_to_send.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict at input transaction, check at output transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        fraction_t want;
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                fractions_due.push_back(approximate(in_ch.value, term_budget,
                                                    stop_threshold));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (fractions_due.size() == 0) begin
                    $error("unexpected result: numerator %0d denominator %0d terms %0d",
                           $signed(out_ch.numerator), out_ch.denominator,
                           out_ch.terms_used);
                    mismatches++;
                end else begin
                    want = fractions_due.pop_front();
                    received++;
                    if (out_ch.numerator !== want.numerator) begin
                        $error("numerator: expected %0d, actual %0d",
                               $signed(want.numerator), $signed(out_ch.numerator));
                        mismatches++;
                    end
                    if (out_ch.denominator !== want.denominator) begin
                        $error("denominator: expected %0d, actual %0d",
                               want.denominator, out_ch.denominator);
                        mismatches++;
                    end
                    if (out_ch.terms_used !== want.terms_used) begin
                        $error("terms_used: expected %0d, actual %0d",
                               want.terms_used, out_ch.terms_used);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycle_count, received, issued);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_MAX_TERMS;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        out_ch.ready   = 1'b0;
        in_taken       = 1'b0;
        term_budget    = MAXT_RESET;
        stop_threshold = PREC_RESET;
        issued         = 0;
        received       = 0;
        mismatches     = 0;
        settings_run   = 1;
        cycle_count    = 0;
        // slow receiver first
        send_idle_pct  = 33;
        recv_idle_pct  = 85;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed values under the reset settings
        send_value(64'h0000_0000_0000_0000);   // zero
        send_value(64'h0000_0000_0000_0001);   // smallest positive
        send_value(64'hFFFF_FFFF_FFFF_FFFF);   // smallest negative
        send_value(64'h7FFF_FFFF_FFFF_FFFF);   // largest positive
        send_value(64'h8000_0000_0000_0000);   // most negative, magnitude 2^63
        send_value(64'h8000_0000_0000_0001);
        send_value(64'h7FFF_FFFF_0000_0000);   // largest whole number
        send_value(64'h0000_0001_0000_0000);   // 1.0
        send_value(64'hFFFF_FFFF_0000_0000);   // -1.0
        send_value(64'h0000_0000_8000_0000);   // exact half
        send_value(64'h0000_0000_4000_0000);   // exact quarter
        send_value(64'h0000_0000_5555_5555);   // near a third
        send_value(64'h0000_0000_AAAA_AAAB);   // near two thirds
        send_value(64'h0000_0003_243F_6A89);   // pi
        send_value(64'hFFFF_FFFC_DBC0_9577);   // -pi
        send_value(64'h0000_0001_9E37_79B9);   // golden ratio, long expansion
        send_value(64'h0000_0000_FFFF_FFFF);   // largest fraction
        send_value(64'h0000_0000_0000_1000);   // remainder under threshold
        send_value(64'h0000_0000_0000_10C7);   // remainder equal to threshold
        send_value(64'h0000_0000_0000_10C8);   // just above threshold
        send_value(64'h0000_0002_0000_0001);
        repeat (40) send_value(random_value());

        // longest expansions, remainder must reach zero
        run_setting(7'd64, 32'd0, 40);

        // slow sender from here
        wait_idle();
        send_idle_pct = 85;
        recv_idle_pct = 33;
        // budget above the cap and a threshold nothing can pass
        run_setting(7'd127, 32'hFFFF_FFFF, 30);
        // no terms at all
        run_setting(7'd0, 32'd0, 20);
        // random moderate setting, sender holds off until the block drains
        run_setting(7'($urandom_range(1, 20)), 32'($urandom_range(0, 65535)), 20);
        wait_idle();
        repeat (20) send_value(random_value());

        // no stalls on either side
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(7'd100, 32'd1, 40);
        run_setting(7'd7, 32'h0010_0000, 40);

        wait_idle();
        // catch any stray result after the last one
        repeat (END_WAIT) @(negedge i_clk);
        if (fractions_due.size() != 0) begin
            $error("%0d expected results never arrived", fractions_due.size());
            mismatches++;
        end

        $display("checked %0d fractions across %0d register settings in %0d cycles",
                 received, settings_run, cycle_count);
        $display("field mismatches or stray results: %0d", mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
